>>> sv/fss_pkg.sv
// Shared constants and types for the flash sector store.
`default_nettype none
package fss_pkg;

  localparam int unsigned SECTORS_PER_BLOCK_DEF = 32;
  localparam int unsigned MAX_BLOCKS_DEF        = 64;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SECTOR_W = 11;
  localparam int unsigned BLOCK_W  = 6;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [BYTE_W-1:0]  ERASED_BYTE       = 8'h30;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERWRITE = 2'd1,
    ST_NO_SECTOR = 2'd2,
    ST_NO_BLOCK  = 2'd3
  } status_t;

endpackage
`default_nettype wire

>>> sv/fss_mem.sv
// Sector byte array: one write port, one read port, registered read data.
`default_nettype none
module fss_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [fss_pkg::BYTE_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [fss_pkg::BYTE_W-1:0] rdata
);
  import fss_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_q[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/fss_ctrl.sv
// Command sequencer: range checks, read-modify-write, erase walk, clearing pass.
`default_nettype none
module fss_ctrl #(
  parameter int unsigned SECTORS_PER_BLOCK = fss_pkg::SECTORS_PER_BLOCK_DEF,
  parameter int unsigned MAX_BLOCKS        = fss_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned DEPTH             = MAX_BLOCKS * SECTORS_PER_BLOCK,
  parameter int unsigned AW                = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [fss_pkg::COUNT_W-1:0]  block_count,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [fss_pkg::CMD_W-1:0]    cmd,
  input  wire logic [fss_pkg::SECTOR_W-1:0] sector_address,
  input  wire logic [fss_pkg::BLOCK_W-1:0]  block_address,
  input  wire logic [fss_pkg::BYTE_W-1:0]   write_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [fss_pkg::BYTE_W-1:0]   read_data,
  output logic      [1:0]                   status,
  output logic                              mem_we,
  output logic      [AW-1:0]                mem_waddr,
  output logic      [fss_pkg::BYTE_W-1:0]   mem_wdata,
  output logic                              mem_re,
  output logic      [AW-1:0]                mem_raddr,
  input  wire logic [fss_pkg::BYTE_W-1:0]   mem_rdata
);
  import fss_pkg::*;

  localparam int unsigned SPB_W  = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
  localparam int unsigned MB_W   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LIM_W  = (MB_W > COUNT_W) ? MB_W : COUNT_W;
  localparam int unsigned DL_W   = $clog2(DEPTH + 1);
  localparam int unsigned SL_W   = (DL_W > SECTOR_W) ? DL_W : SECTOR_W;
  localparam int unsigned EXT_W  = (AW > SECTOR_W) ? AW : SECTOR_W;

  localparam logic [LIM_W-1:0] MAX_BLK_L  = LIM_W'(MAX_BLOCKS);
  localparam logic [SL_W-1:0]  SPB_L      = SL_W'(SECTORS_PER_BLOCK);
  localparam logic [AW-1:0]    SPB_A      = AW'(SECTORS_PER_BLOCK);
  localparam logic [SPB_W-1:0] SPB_LAST   = SPB_W'(SECTORS_PER_BLOCK - 1);
  localparam logic [AW-1:0]    DEPTH_LAST = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ACCESS = 5'b00100,
    S_ERASE  = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t              state;
  logic [CMD_W-1:0]    cmd_q;
  logic [AW-1:0]       addr_q;
  logic [BYTE_W-1:0]   wdata_q;
  status_t             resp_q;
  logic [AW-1:0]       addr_cnt;
  logic [SPB_W-1:0]    sec_cnt;

  logic [LIM_W-1:0]    avail;
  logic [SL_W-1:0]     sect_lim;
  logic                sector_bad;
  logic                block_bad;
  logic [EXT_W-1:0]    sec_ext;
  logic                in_fire;
  logic                slot_free;
  logic                rd_erased;
  logic                resp_load;

  assign avail      = (LIM_W'(block_count) > MAX_BLK_L) ? MAX_BLK_L : LIM_W'(block_count);
  // sector limit is at most the store depth, so it covers the depth check too
  assign sect_lim   = SL_W'(avail) * SPB_L;
  assign sector_bad = SL_W'(sector_address) >= sect_lim;
  assign block_bad  = LIM_W'(block_address) >= avail;
  assign sec_ext    = EXT_W'(sector_address);

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign rd_erased = (mem_rdata == ERASED_BYTE);
  assign resp_load = slot_free && ((state == S_ACCESS) || (state == S_RESP) ||
                                   (state == S_ERASE && sec_cnt == SPB_LAST));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_cnt;
    mem_wdata = ERASED_BYTE;
    unique case (state)
      S_CLEAR, S_ERASE: begin
        mem_we = 1'b1;
      end
      S_ACCESS: begin
        mem_we    = slot_free && (cmd_q == CMD_WRITE) && rd_erased;
        mem_waddr = addr_q;
        mem_wdata = wdata_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re    = in_fire;
  assign mem_raddr = sec_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr_cnt  <= '0;
      sec_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= resp_load || (out_valid && !out_ready);
      unique case (state)
        S_CLEAR: begin
          addr_cnt <= addr_cnt + 1'b1;
          if (addr_cnt == DEPTH_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_q   <= cmd;
            addr_q  <= sec_ext[AW-1:0];
            wdata_q <= write_data;
            if (cmd == CMD_READ || cmd == CMD_WRITE) begin
              if (sector_bad) begin
                resp_q <= ST_NO_SECTOR;
                state  <= S_RESP;
              end else begin
                state <= S_ACCESS;
              end
            end else if (cmd == CMD_ERASE) begin
              if (block_bad) begin
                resp_q <= ST_NO_BLOCK;
                state  <= S_RESP;
              end else begin
                addr_cnt <= AW'(block_address) * SPB_A;
                sec_cnt  <= '0;
                state    <= S_ERASE;
              end
            end else begin
              resp_q <= ST_DONE;
              state  <= S_RESP;
            end
          end
        end
        S_ACCESS: begin
          // read data is held in the memory output register while stalled
          if (slot_free) begin
            read_data <= (cmd_q == CMD_READ) ? mem_rdata : '0;
            status    <= (cmd_q == CMD_WRITE && !rd_erased) ? ST_OVERWRITE : ST_DONE;
            state     <= S_IDLE;
          end
        end
        S_ERASE: begin
          if (sec_cnt != SPB_LAST) begin
            addr_cnt <= addr_cnt + 1'b1;
            sec_cnt  <= sec_cnt + 1'b1;
          end else if (slot_free) begin
            // last sector is rewritten harmlessly while the result stalls
            read_data <= '0;
            status    <= ST_DONE;
            state     <= S_IDLE;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            read_data <= '0;
            status    <= resp_q;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/flash_sector_store_with_block_erase_top.sv
// Top level of the flash sector store with block erase.
//
//   channel | direction | handshake            | beat carries
//   --------+-----------+----------------------+-----------------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_data (block_count)
//   in      | in        | in_valid/in_ready    | cmd, sector_address, block_address, write_data
//   out     | out       | out_valid/out_ready  | read_data, status
//
// Read and write: memory read on accept, then check and write-back once the result slot is free.
// Erase walks the block, one sector written per cycle.
// Out-of-range commands and the unused code go straight to the response state.
// After reset a clearing pass writes the erased byte to all MAX_BLOCKS * SECTORS_PER_BLOCK
// sectors; in_ready stays low until it ends. While a result stalls, the next beat is
// still taken, but its result waits and in_ready stays low until the stall clears.
`default_nettype none
module flash_sector_store_with_block_erase_top #(
  parameter int unsigned SECTORS_PER_BLOCK = fss_pkg::SECTORS_PER_BLOCK_DEF,
  parameter int unsigned MAX_BLOCKS        = fss_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [fss_pkg::COUNT_W-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [fss_pkg::CMD_W-1:0]    cmd,
  input  wire logic [fss_pkg::SECTOR_W-1:0] sector_address,
  input  wire logic [fss_pkg::BLOCK_W-1:0]  block_address,
  input  wire logic [fss_pkg::BYTE_W-1:0]   write_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [fss_pkg::BYTE_W-1:0]   read_data,
  output logic      [1:0]                   status
);
  import fss_pkg::*;

  localparam int unsigned DEPTH = MAX_BLOCKS * SECTORS_PER_BLOCK;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [COUNT_W-1:0] block_count;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [BYTE_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [BYTE_W-1:0]  mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_count <= cfg_data;
    end
  end

  fss_ctrl #(
    .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK),
    .MAX_BLOCKS        (MAX_BLOCKS),
    .DEPTH             (DEPTH),
    .AW                (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .block_count    (block_count),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .sector_address (sector_address),
    .block_address  (block_address),
    .write_data     (write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .status         (status),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  fss_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

>>> dv/flash_sector_store_with_block_erase_checker.sv
// Checker for the flash sector store: tracks the sector array and compares every result.
`timescale 1ns / 100ps
`default_nettype none
module flash_sector_store_with_block_erase_checker
  import fss_pkg::*;
#(
  parameter int unsigned SECTORS_PER_BLOCK = SECTORS_PER_BLOCK_DEF,
  parameter int unsigned MAX_BLOCKS        = MAX_BLOCKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [COUNT_W-1:0]  cfg_data,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [SECTOR_W-1:0] sector_address,
  input  wire logic [BLOCK_W-1:0]  block_address,
  input  wire logic [BYTE_W-1:0]   write_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [BYTE_W-1:0]   read_data,
  input  wire logic [1:0]          status,
  output int                       mismatches,
  output int                       outstanding
);

  localparam int unsigned ARRAY_DEPTH = MAX_BLOCKS * SECTORS_PER_BLOCK;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    status_t           code;
  } flash_reply_t;

  logic [BYTE_W-1:0]  sector_mem [0:ARRAY_DEPTH-1];
  logic [COUNT_W-1:0] block_limit;
  flash_reply_t       due_replies [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic flag(input string what);
    if (mismatches < 10) $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Applies one command to the shadow array and returns what the block should answer.
  function automatic flash_reply_t apply_flash_cmd(input logic [CMD_W-1:0] op,
                                                   input logic [SECTOR_W-1:0] sa,
                                                   input logic [BLOCK_W-1:0] ba,
                                                   input logic [BYTE_W-1:0] wd);
    flash_reply_t r;
    int unsigned  avail;
    r.byte_out = '0;
    r.code     = ST_DONE;
    avail = (block_limit > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_limit);
    case (op)
      CMD_READ, CMD_WRITE: begin
        if (sa / SECTORS_PER_BLOCK >= avail || sa >= ARRAY_DEPTH) begin
          r.code = ST_NO_SECTOR;
        end else if (op == CMD_READ) begin
          r.byte_out = sector_mem[sa];
        end else if (sector_mem[sa] == ERASED_BYTE) begin
          sector_mem[sa] = wd;
        end else begin
          r.code = ST_OVERWRITE;
        end
      end
      CMD_ERASE: begin
        if (ba >= avail) begin
          r.code = ST_NO_BLOCK;
        end else begin
          for (int k = 0; k < SECTORS_PER_BLOCK; k++)
            sector_mem[ba * SECTORS_PER_BLOCK + k] = ERASED_BYTE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    flash_reply_t want;
    if (rst) begin
      for (int k = 0; k < ARRAY_DEPTH; k++) sector_mem[k] = ERASED_BYTE;
      block_limit = BLOCK_COUNT_RESET;
      due_replies.delete();
    end else begin
      // results always leave in a later cycle than their command, so check before pushing
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          flag($sformatf("unexpected result: read_data=%02h status=%0d", read_data, status));
        end else begin
          want = due_replies.pop_front();
          if (read_data !== want.byte_out || status !== want.code)
            flag($sformatf("result mismatch: read_data exp %02h got %02h, status exp %s got %0d",
                           want.byte_out, read_data, want.code.name(), status));
        end
      end
      if (cfg_valid && cfg_ready) block_limit = cfg_data;
      if (in_valid && in_ready)
        due_replies.push_back(apply_flash_cmd(cmd, sector_address, block_address, write_data));
    end
    outstanding <= due_replies.size();
  end

endmodule
`default_nettype wire

>>> dv/flash_sector_store_with_block_erase_top_tb.sv
// Testbench top for the flash sector store: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
`default_nettype none
module flash_sector_store_with_block_erase_top_tb;
  import fss_pkg::*;

  localparam int unsigned SPB = SECTORS_PER_BLOCK_DEF;
  localparam int unsigned NBLK = MAX_BLOCKS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = '0;
  logic [SECTOR_W-1:0] sector_address = '0;
  logic [BLOCK_W-1:0]  block_address = '0;
  logic [BYTE_W-1:0]   write_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   read_data;
  logic [1:0]          status;

  int                  mismatches;
  int                  outstanding;
  pace_t               pace = PACE_FREE;
  int unsigned         blocks_now = NBLK;

  always #4 clk = ~clk;

  flash_sector_store_with_block_erase_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .sector_address (sector_address),
    .block_address  (block_address),
    .write_data     (write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .status         (status)
  );

  flash_sector_store_with_block_erase_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .sector_address (sector_address),
    .block_address  (block_address),
    .write_data     (write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .status         (status),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    case (pace)
      PACE_RECEIVER: out_ready <= ($urandom_range(0, 99) >= 57);
      PACE_BOTH:     out_ready <= ($urandom_range(0, 99) >= 8);
      default:       out_ready <= 1'b1;
    endcase
  end

  function automatic bit sender_rests();
    case (pace)
      PACE_SENDER: return $urandom_range(0, 99) < 57;
      PACE_BOTH:   return $urandom_range(0, 99) < 8;
      default:     return 1'b0;
    endcase
  endfunction

  // valid is left high after the beat; the next call or a drain decides whether it drops
  task automatic issue_cmd(input logic [CMD_W-1:0] op, input logic [SECTOR_W-1:0] sa,
                           input logic [BLOCK_W-1:0] ba, input logic [BYTE_W-1:0] wd);
    while (sender_rests()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= op;
    sector_address <= sa;
    block_address  <= ba;
    write_data     <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_blocks(input int unsigned n);
    drain_replies();
    repeat (SPB + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= COUNT_W'(n);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    blocks_now = (n > NBLK) ? NBLK : n;
  endtask

  // Mostly commands aimed at a few present blocks so writes, overwrites and erases collide.
  task automatic issue_random_cmd();
    int unsigned      roll;
    int unsigned      spread;
    int unsigned      hot;
    logic [CMD_W-1:0] op;
    logic [SECTOR_W-1:0] sa;
    logic [BLOCK_W-1:0]  ba;
    roll = $urandom_range(0, 99);
    if (roll < 40) op = CMD_READ;
    else if (roll < 78) op = CMD_WRITE;
    else if (roll < 94) op = CMD_ERASE;
    else op = CMD_UNUSED;
    sa = SECTOR_W'($urandom);
    ba = BLOCK_W'($urandom);
    spread = $urandom_range(0, 99);
    if (blocks_now != 0 && spread >= 12) begin
      if (spread < 60) hot = $urandom_range(0, (blocks_now < 3 ? blocks_now : 3) - 1);
      else if (spread < 75) hot = blocks_now - 1;
      else hot = $urandom_range(0, blocks_now - 1);
      sa = SECTOR_W'(hot * SPB + $urandom_range(0, SPB - 1));
      ba = BLOCK_W'(hot);
    end
    issue_cmd(op, sa, ba, BYTE_W'($urandom));
  endtask

  task automatic run_phase(input int unsigned n_blocks, input pace_t p,
                           input int unsigned n_items, input bit hold_mid);
    set_blocks(n_blocks);
    pace = p;
    for (int k = 0; k < n_items; k++) begin
      if (hold_mid && k == n_items / 2) drain_replies();
      issue_random_cmd();
    end
  endtask

  initial begin
    #(8 * 750_000);
    $display("flash_sector_store_with_block_erase_top_tb: errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fresh array, overwrite rule, first and last sectors, erase edges
    issue_cmd(CMD_READ,  11'd0,    6'd0,  8'h00);
    issue_cmd(CMD_WRITE, 11'd0,    6'd0,  8'h00);
    issue_cmd(CMD_READ,  11'd0,    6'd0,  8'h00);
    issue_cmd(CMD_WRITE, 11'd0,    6'd0,  8'hFF);
    issue_cmd(CMD_WRITE, 11'd5,    6'd0,  ERASED_BYTE);  // still reads as erased
    issue_cmd(CMD_WRITE, 11'd5,    6'd0,  8'hC3);
    issue_cmd(CMD_WRITE, 11'd2047, 6'd63, 8'hFF);
    issue_cmd(CMD_READ,  11'd2047, 6'd63, 8'h00);
    issue_cmd(CMD_ERASE, 11'd0,    6'd63, 8'h00);
    issue_cmd(CMD_READ,  11'd2047, 6'd0,  8'h00);
    issue_cmd(CMD_WRITE, 11'd31,   6'd0,  8'hA5);
    issue_cmd(CMD_WRITE, 11'd32,   6'd0,  8'h5A);
    issue_cmd(CMD_ERASE, 11'd2047, 6'd0,  8'h00);
    issue_cmd(CMD_READ,  11'd31,   6'd0,  8'h00);
    issue_cmd(CMD_READ,  11'd32,   6'd0,  8'h00);
    issue_cmd(CMD_UNUSED, 11'h7FF, 6'h3F, 8'hFF);
    issue_cmd(CMD_WRITE, 11'd40,   6'd1,  8'h7E);
    set_blocks(1);
    issue_cmd(CMD_READ,  11'd32,   6'd0,  8'h00);
    issue_cmd(CMD_ERASE, 11'd0,    6'd1,  8'h00);
    issue_cmd(CMD_READ,  11'd2047, 6'd0,  8'h00);
    issue_cmd(CMD_ERASE, 11'd0,    6'd63, 8'h00);
    set_blocks(0);
    issue_cmd(CMD_READ,  11'd0,    6'd0,  8'h00);
    issue_cmd(CMD_ERASE, 11'd0,    6'd0,  8'h00);
    set_blocks(127);  // clamps to the full array; block 1 keeps its byte
    issue_cmd(CMD_READ,  11'd40,   6'd0,  8'h00);
    issue_cmd(CMD_ERASE, 11'd0,    6'd63, 8'h00);

    run_phase(64,  PACE_FREE,     200, 1'b0);
    run_phase(64,  PACE_SENDER,   200, 1'b1);
    run_phase(3,   PACE_RECEIVER, 200, 1'b0);
    run_phase(127, PACE_BOTH,     200, 1'b0);
    run_phase(1,   PACE_SENDER,   120, 1'b0);
    run_phase(0,   PACE_FREE,      40, 1'b0);
    run_phase(65,  PACE_RECEIVER, 150, 1'b0);
    run_phase(37,  PACE_BOTH,     100, 1'b0);
    run_phase(64,  PACE_FREE,     100, 1'b0);

    drain_replies();
    repeat (SPB + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("flash_sector_store_with_block_erase_top_tb: clean");
    end else begin
      $display("flash_sector_store_with_block_erase_top_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
